// ===== design/rtfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Radiotap field parser package
// Shared constants, the field size table, and the result and phase types.
// ----------------------------------------------------------------------------
package rtfp_pkg;

  // Fields walked: the known fields, capped at the size of the table
  localparam int unsigned KNOWN_FIELDS    = 14;
  localparam int unsigned TABLE_FIELDS    = 14;
  localparam int unsigned FIELD_LIMIT     = (KNOWN_FIELDS < TABLE_FIELDS) ?
                                            KNOWN_FIELDS : TABLE_FIELDS;
  localparam int unsigned MAX_FIELD_BYTES = 8;
  localparam int unsigned RES_FIFO_DEPTH  = 4;

  // Bitmap word bit that chains a further bitmap word
  localparam int unsigned EXT_BIT = 31;

  // Size codes: alignment in the high nibble, length in the low nibble
  localparam logic [7:0] SZ_U64   = 8'h88;
  localparam logic [7:0] SZ_U8    = 8'h11;
  localparam logic [7:0] SZ_U32   = 8'h24;
  localparam logic [7:0] SZ_U16   = 8'h22;
  localparam logic [7:0] LEN_MASK = 8'h0f;

  typedef enum logic [1:0] {
    ST_FIELD,
    ST_DONE,
    ST_BAD_VERSION,
    ST_ERROR
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HDR,
    PH_BITMAP,
    PH_COLLECT
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  field_index;
    logic [63:0] field_value;
    logic [3:0]  field_bytes;
    logic        last_of_run;
  } res_t;

  function automatic logic [7:0] field_size(input logic [3:0] idx);
    logic [7:0] sz;
    unique case (idx)
      4'd0:                             sz = SZ_U64;
      4'd1, 4'd2, 4'd5, 4'd6:           sz = SZ_U8;
      4'd3:                             sz = SZ_U32;
      4'd4, 4'd7, 4'd8, 4'd9:           sz = SZ_U16;
      4'd10, 4'd11, 4'd12, 4'd13:       sz = SZ_U8;
      default:                          sz = 8'h00;
    endcase
    return sz;
  endfunction

  function automatic logic [3:0] size_align(input logic [7:0] sz);
    return sz[7:4];
  endfunction

  function automatic logic [3:0] size_len(input logic [7:0] sz);
    logic [7:0] len;
    len = sz & LEN_MASK;
    return len[3:0];
  endfunction

endpackage

// ===== design/rtfp_res_fifo.sv =====
// ----------------------------------------------------------------------------
// Radiotap field parser result queue
// Small queue that takes up to two results a cycle and hands out one unless stalled.
// ----------------------------------------------------------------------------
module rtfp_res_fifo #(
  parameter int unsigned DEPTH = rtfp_pkg::RES_FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     push_cnt,
  input  rtfp_pkg::res_t push_data0,
  input  rtfp_pkg::res_t push_data1,
  output logic           room2,
  output logic           valid,
  input  logic           stall,
  output rtfp_pkg::res_t head
);
  import rtfp_pkg::*;

  // DEPTH is a power of two, at least 2
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  res_t           entries [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           pop;

  assign valid = (count != '0);
  assign pop   = valid && !stall;
  assign room2 = (count <= CW'(DEPTH - 2));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push_cnt);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count + CW'(push_cnt) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entries[wr_ptr] <= push_data0;
    end
    if (push_cnt == 2'd2) begin
      entries[wr_ptr + AW'(1)] <= push_data1;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue count above depth");

  assert property (@(posedge clk) disable iff (rst)
    push_cnt != 2'd0 |-> count <= CW'(DEPTH - 2))
    else $error("results pushed without room for two");

  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + CW'($past(push_cnt)) - CW'($past(pop)))
    else $error("result queue count out of step with pushes and pops");

endmodule

// ===== design/rtfp_walk.sv =====
// ----------------------------------------------------------------------------
// Radiotap field parser walker
// Parse state and one-byte step: header, bitmaps, field search and collect.
// ----------------------------------------------------------------------------
module rtfp_walk (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic [7:0]     data_byte,
  input  logic           frame_start,
  input  logic [15:0]    frame_length,
  output logic [1:0]     push_cnt,
  output rtfp_pkg::res_t res0,
  output rtfp_pkg::res_t res1
);
  import rtfp_pkg::*;

  // Registered parse state
  phase_t                 phase;
  logic [15:0]            byte_offset;
  logic [15:0]            header_length;
  logic [FIELD_LIMIT-1:0] present_bits;
  logic [3:0]             current_field;
  logic [3:0]             bytes_collected;
  logic [63:0]            value_accumulator;
  logic [15:0]            sampled_length;
  logic [15:0]            next_pos;
  logic [15:0]            field_start;
  logic [3:0]             field_len;

  // State as seen by this byte (a frame start restarts everything)
  phase_t                 ph_e;
  logic [15:0]            off_e;
  logic [15:0]            hl_e;
  logic [FIELD_LIMIT-1:0] pb_e;
  logic [3:0]             cur_e;
  logic [3:0]             bc_e;
  logic [63:0]            acc_e;
  logic [15:0]            sl_e;
  logic [15:0]            np_e;
  logic [15:0]            fs_e;
  logic [3:0]             fl_e;

  // Next values
  phase_t                 phase_next;
  logic [15:0]            byte_offset_next;
  logic [15:0]            header_length_next;
  logic [FIELD_LIMIT-1:0] present_bits_next;
  logic [3:0]             current_field_next;
  logic [3:0]             bytes_collected_next;
  logic [63:0]            value_accumulator_next;
  logic [15:0]            sampled_length_next;
  logic [15:0]            next_pos_next;
  logic [15:0]            field_start_next;
  logic [3:0]             field_len_next;

  // Step datapath
  logic [15:0]            q;
  logic                   q_low;
  logic                   word_end;
  logic                   ext;
  logic [16:0]            p1;
  logic [31:0]            word_upd;
  logic [FIELD_LIMIT-1:0] pb_upd;
  logic [15:0]            hl_upd;
  logic                   bad_version;
  logic                   len_bad;
  logic                   runaway;
  logic                   col_take;
  logic                   col_done;
  logic [3:0]             bc_inc;
  logic [63:0]            acc_upd;

  // Next-field search
  logic [3:0]             adv_from;
  logic [FIELD_LIMIT-1:0] adv_present;
  logic [16:0]            adv_pos;
  logic                   adv_found;
  logic [3:0]             adv_idx;
  logic [7:0]             adv_sz;
  logic [3:0]             adv_al;
  logic [3:0]             adv_len;
  logic [2:0]             adv_mask;
  logic [2:0]             adv_pad;
  logic [17:0]            adv_start;
  logic [17:0]            adv_end;
  logic                   adv_ok;
  res_t                   adv_res;

  logic [1:0]             res_cnt;
  res_t                   last_res;

  always_comb begin
    if (frame_start) begin
      ph_e  = PH_HDR;
      off_e = '0;
      hl_e  = '0;
      pb_e  = '0;
      cur_e = '0;
      bc_e  = '0;
      acc_e = '0;
      sl_e  = frame_length;
      np_e  = '0;
      fs_e  = '0;
      fl_e  = '0;
    end else begin
      ph_e  = phase;
      off_e = byte_offset;
      hl_e  = header_length;
      pb_e  = present_bits;
      cur_e = current_field;
      bc_e  = bytes_collected;
      acc_e = value_accumulator;
      sl_e  = sampled_length;
      np_e  = next_pos;
      fs_e  = field_start;
      fl_e  = field_len;
    end
  end

  always_comb begin
    q        = off_e - 16'd4;
    q_low    = (q[15:2] == '0);
    word_end = (q[1:0] == 2'b11);
    ext      = data_byte[EXT_BIT % 8];
    p1       = {1'b0, off_e} + 17'd1;
    word_upd = 32'(pb_e);
    if (q_low) begin
      word_upd = word_upd | (32'(data_byte) << {q[1:0], 3'b000});
    end
    pb_upd   = word_upd[FIELD_LIMIT-1:0];

    hl_upd = hl_e;
    if (off_e == 16'd2) begin
      hl_upd = {8'h00, data_byte};
    end else if (off_e == 16'd3) begin
      hl_upd = {data_byte, hl_e[7:0]};
    end
    bad_version = (off_e == 16'd0) && (data_byte != 8'h00);
    len_bad     = (sl_e < hl_upd);
    runaway     = (p1 > {1'b0, hl_e});

    col_take = (off_e >= fs_e) && (bc_e < 4'(MAX_FIELD_BYTES));
    bc_inc   = bc_e + 4'd1;
    col_done = col_take && (bc_inc >= fl_e);
    acc_upd  = acc_e | (64'(data_byte) << {bc_e[2:0], 3'b000});

    // One search unit serves both the end of the bitmaps and the end of a field
    if (ph_e == PH_BITMAP) begin
      adv_from    = 4'd0;
      adv_present = pb_upd;
      adv_pos     = p1;
    end else begin
      adv_from    = cur_e + 4'd1;
      adv_present = pb_e;
      adv_pos     = {1'b0, np_e};
    end

    adv_found = 1'b0;
    adv_idx   = '0;
    for (int i = FIELD_LIMIT - 1; i >= 0; i--) begin
      if (adv_present[i] && (4'(i) >= adv_from)) begin
        adv_found = 1'b1;
        adv_idx   = 4'(i);
      end
    end

    adv_sz    = field_size(adv_idx);
    adv_al    = size_align(adv_sz);
    adv_len   = size_len(adv_sz);
    adv_mask  = 3'(adv_al - 4'd1);
    adv_pad   = (3'(~adv_pos[2:0]) + 3'd1) & adv_mask;
    adv_start = 18'(adv_pos) + 18'(adv_pad);
    adv_end   = adv_start + 18'(adv_len);
    adv_ok    = adv_found && (adv_end <= 18'(hl_e));

    adv_res = '0;
    if (adv_found) begin
      adv_res.status      = ST_ERROR;
      adv_res.field_index = adv_idx;
      adv_res.field_bytes = adv_len;
    end else begin
      adv_res.status      = ST_DONE;
    end
  end

  // Next state
  always_comb begin
    phase_next             = ph_e;
    byte_offset_next       = off_e;
    header_length_next     = hl_e;
    present_bits_next      = pb_e;
    current_field_next     = cur_e;
    bytes_collected_next   = bc_e;
    value_accumulator_next = acc_e;
    sampled_length_next    = sl_e;
    next_pos_next          = np_e;
    field_start_next       = fs_e;
    field_len_next         = fl_e;

    if (ph_e != PH_IDLE) begin
      byte_offset_next = off_e + 16'd1;
    end

    unique case (ph_e)
      PH_IDLE: begin
      end
      PH_HDR: begin
        header_length_next = hl_upd;
        if (bad_version) begin
          phase_next = PH_IDLE;
        end else if (off_e == 16'd3) begin
          phase_next = len_bad ? PH_IDLE : PH_BITMAP;
        end
      end
      PH_BITMAP: begin
        present_bits_next = pb_upd;
        if (word_end) begin
          if (ext) begin
            if (runaway) begin
              phase_next = PH_IDLE;
            end
          end else if (adv_ok) begin
            phase_next             = PH_COLLECT;
            current_field_next     = adv_idx;
            field_start_next       = adv_start[15:0];
            field_len_next         = adv_len;
            bytes_collected_next   = '0;
            value_accumulator_next = '0;
            next_pos_next          = adv_end[15:0];
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_COLLECT: begin
        if (col_take) begin
          bytes_collected_next   = bc_inc;
          value_accumulator_next = acc_upd;
          if (col_done) begin
            current_field_next = cur_e + 4'd1;
            if (adv_ok) begin
              current_field_next     = adv_idx;
              field_start_next       = adv_start[15:0];
              field_len_next         = adv_len;
              bytes_collected_next   = '0;
              value_accumulator_next = '0;
              next_pos_next          = adv_end[15:0];
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
      end
    endcase
  end

  // Results
  always_comb begin
    res0    = '0;
    res1    = '0;
    res_cnt = 2'd0;

    unique case (ph_e)
      PH_IDLE: begin
      end
      PH_HDR: begin
        if (bad_version) begin
          res0.status = ST_BAD_VERSION;
          res_cnt     = 2'd1;
        end else if ((off_e == 16'd3) && len_bad) begin
          res0.status = ST_ERROR;
          res_cnt     = 2'd1;
        end
      end
      PH_BITMAP: begin
        if (word_end) begin
          if (ext) begin
            if (runaway) begin
              res0.status = ST_ERROR;
              res_cnt     = 2'd1;
            end
          end else if (!adv_ok) begin
            res0    = adv_res;
            res_cnt = 2'd1;
          end
        end
      end
      PH_COLLECT: begin
        if (col_done) begin
          res0.status      = ST_FIELD;
          res0.field_index = cur_e;
          res0.field_value = acc_upd;
          res0.field_bytes = fl_e;
          res_cnt          = 2'd1;
          if (!adv_ok) begin
            res1    = adv_res;
            res_cnt = 2'd2;
          end
        end
      end
    endcase

    if (res_cnt == 2'd2) begin
      res1.last_of_run = 1'b1;
    end else begin
      res0.last_of_run = 1'b1;
    end
    push_cnt = fire ? res_cnt : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (fire) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_offset       <= byte_offset_next;
      header_length     <= header_length_next;
      present_bits      <= present_bits_next;
      current_field     <= current_field_next;
      bytes_collected   <= bytes_collected_next;
      value_accumulator <= value_accumulator_next;
      sampled_length    <= sampled_length_next;
      next_pos          <= next_pos_next;
      field_start       <= field_start_next;
      field_len         <= field_len_next;
    end
  end

  assign last_res = (res_cnt == 2'd2) ? res1 : res0;

  assert property (@(posedge clk) disable iff (rst)
    res_cnt == 2'd2 |-> res0.status == ST_FIELD)
    else $error("two results without a field first");

  assert property (@(posedge clk) disable iff (rst)
    fire && res_cnt != 2'd0 && last_res.status != ST_FIELD |=> phase == PH_IDLE)
    else $error("walk continues after done or error");

  assert property (@(posedge clk) disable iff (rst)
    phase == PH_COLLECT |-> bytes_collected < field_len)
    else $error("collecting a field that is already complete");

endmodule

// ===== design/radiotap_header_field_parser_top.sv =====
// ----------------------------------------------------------------------------
// Radiotap header field parser
// Walks a radiotap capture header byte by byte and reports each known field.
// ----------------------------------------------------------------------------
// The parser takes one frame byte per transaction on the byte channel, at a
// sustained rate of one byte per clock when not stalled. Each byte passes an
// input register, then a single combinational step (header checks, bitmap
// gathering, a fixed priority search for the next present field and its
// alignment) updates the parse state and yields zero, one or two results.
// Results go into a four entry queue feeding the result channel, which
// delivers one transaction per cycle unless stalled; a byte that yields two
// results (a field followed by done or by an overrun of the next field)
// therefore offers them one after the other. The byte channel stalls only
// while the queue lacks room for two results. Each byte is registered and
// its results queued before being offered. frame_start restarts the walk
// on any byte; bytes outside a header walk are dropped without a result.
module radiotap_header_field_parser_top #(
  parameter int unsigned RES_FIFO_DEPTH = rtfp_pkg::RES_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  input  logic [15:0] frame_length,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  status,
  output logic [3:0]  field_index,
  output logic [63:0] field_value,
  output logic [3:0]  field_bytes,
  output logic        last_of_run
);
  import rtfp_pkg::*;

  // Input register
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_start;
  logic [15:0] s1_length;

  logic        room2;
  logic        fire;
  logic [1:0]  push_cnt;
  res_t        res0;
  res_t        res1;
  res_t        head;

  // Advance the held byte only when the queue can take both possible results
  assign fire       = s1_valid && room2;
  assign byte_stall = s1_valid && !room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture payload on every accepted transaction; hold otherwise
  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_byte   <= data_byte;
      s1_start  <= frame_start;
      s1_length <= frame_length;
    end
  end

  rtfp_walk u_walk (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .data_byte    (s1_byte),
    .frame_start  (s1_start),
    .frame_length (s1_length),
    .push_cnt     (push_cnt),
    .res0         (res0),
    .res1         (res1)
  );

  rtfp_res_fifo #(
    .DEPTH (RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_cnt   (push_cnt),
    .push_data0 (res0),
    .push_data1 (res1),
    .room2      (room2),
    .valid      (result_valid),
    .stall      (result_stall),
    .head       (head)
  );

  // Drive the result ports from the queue head
  assign status      = head.status;
  assign field_index = head.field_index;
  assign field_value = head.field_value;
  assign field_bytes = head.field_bytes;
  assign last_of_run = head.last_of_run;

  assert property (@(posedge clk) disable iff (rst)
    push_cnt != 2'd0 |-> fire)
    else $error("results produced without an advancing byte");

  assert property (@(posedge clk) disable iff (rst)
    byte_stall |=> s1_valid)
    else $error("held byte lost while stalled");

  assert property (@(posedge clk) disable iff (rst)
    fire && !(byte_valid && !byte_stall) |=> !s1_valid)
    else $error("input register not emptied after advancing");

endmodule
